// ===== design/jei_pkg.sv =====
// Shared types and constants for the Julia escape-time evaluator.
`timescale 1ns / 1ps

package jei_pkg;

    localparam int IDX_W     = 20;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;
    localparam int FRAC_BITS = 28;
    localparam int OPND_W    = 33;
    localparam int PROD_W    = 2 * OPND_W;
    localparam int WIDE_W    = PROD_W + 1;
    localparam int SQ_W      = 37;
    localparam int SUM_W     = 38;
    localparam int CNT_W     = 9;

    // 4.0 in Q10.28
    localparam logic signed [SUM_W-1:0] ESC_LIMIT = SUM_W'(64'sd4 <<< FRAC_BITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_MIN    = 3'd0,
        CFG_Y_MAX    = 3'd1,
        CFG_X_STEP   = 3'd2,
        CFG_Y_STEP   = 3'd3,
        CFG_C_REAL   = 3'd4,
        CFG_C_IMAG   = 3'd5,
        CFG_MAX_ITER = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ROW,
        ST_COL,
        ST_MUL,
        ST_START,
        ST_SQ,
        ST_UPD
    } state_t;

    // operand pairs for the three multipliers of the shared unit
    typedef struct packed {
        logic signed [OPND_W-1:0] a0;
        logic signed [OPND_W-1:0] b0;
        logic signed [OPND_W-1:0] a1;
        logic signed [OPND_W-1:0] b1;
        logic signed [OPND_W-1:0] a2;
        logic signed [OPND_W-1:0] b2;
    } mul_ops_t;

    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(64'sd2147483647);
        lo = WIDE_W'(-64'sd2147483648);
        if (v > hi)
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (v < lo)
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

// ===== design/jei_mul_unit.sv =====
// Shared multiplier bank: three signed products, each registered.
`timescale 1ns / 1ps

module jei_mul_unit (
    input  logic                                clk,
    input  jei_pkg::mul_ops_t                   ops,
    output logic signed [jei_pkg::PROD_W-1:0]   p0,
    output logic signed [jei_pkg::PROD_W-1:0]   p1,
    output logic signed [jei_pkg::PROD_W-1:0]   p2
);
    import jei_pkg::*;

    logic signed [PROD_W-1:0] p0_reg;
    logic signed [PROD_W-1:0] p1_reg;
    logic signed [PROD_W-1:0] p2_reg;

    always_ff @(posedge clk)
    begin
        p0_reg <= ops.a0 * ops.b0;
        p1_reg <= ops.a1 * ops.b1;
        p2_reg <= ops.a2 * ops.b2;
    end

    assign p0 = p0_reg;
    assign p1 = p1_reg;
    assign p2 = p2_reg;

endmodule

// ===== design/julia_escape_iteration.sv =====
// Julia set escape-time evaluator, one pixel at a time.
// Usage:
//   Pixel channel: pixel_valid / pixel_stall carry pixel_index. A transfer
//   happens when pixel_valid is high and pixel_stall is low. pixel_stall is
//   low only while the block is idle; one pixel is worked at a time.
//   Result channel: result_valid / result_stall carry escape_count and the
//   three color bytes. A result register holds the value while the receiver
//   stalls; a new pixel may be accepted meanwhile, but its result waits
//   until the register is free.
//   Config channel: cfg_valid / cfg_ready with cfg_index, cfg_data. Always
//   ready; write only while no pixel is in flight.
// Timing: setup runs through ST_DIV and ST_ROW (row by reciprocal
//   multiply), ST_COL (column), ST_MUL and ST_START (start point), then
//   each escape test takes ST_SQ for the three products x*x, y*y, x*y in
//   the shared multiplier bank and ST_UPD for the escape compare and the z
//   update. The number of z updates is at most max_iterations; the next
//   pixel is taken the cycle after the result is written.
// Reset: rst_n (async, low) idles the block, drops result_valid and
//   loads the default view and Julia constant.
`timescale 1ns / 1ps

module julia_escape_iteration #(
    parameter int DIM = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pixel_valid,
    output logic                            pixel_stall,
    input  logic [jei_pkg::IDX_W-1:0]       pixel_index,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [7:0]                      escape_count,
    output logic [7:0]                      red,
    output logic [7:0]                      green,
    output logic [7:0]                      blue,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [jei_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [jei_pkg::CFG_W-1:0]       cfg_data
);
    import jei_pkg::*;

    localparam int COL_W  = $clog2(DIM);
    localparam int ROW_W  = $clog2(((1 << IDX_W) - 1) / DIM + 1);
    localparam int DIV_SH = IDX_W + $clog2(DIM);
    // ceil(2^DIV_SH / DIM): exact floor division for every 20-bit index
    localparam longint unsigned DIV_MUL = ((64'd1 << DIV_SH) + DIM - 1) / DIM;
    localparam logic [IDX_W-1:0] DIM_U = IDX_W'(DIM);

    // config registers
    logic signed [31:0] x_min_reg;
    logic signed [31:0] y_max_reg;
    logic [30:0]        x_step_reg;
    logic [30:0]        y_step_reg;
    logic signed [30:0] c_real_reg;
    logic signed [30:0] c_imag_reg;
    logic [7:0]         max_iter_reg;

    // control
    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;

    // datapath
    logic [IDX_W-1:0]   idx_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [COL_W-1:0]   col_reg;
    logic signed [31:0] x_reg;
    logic signed [31:0] y_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [7:0]         cnt_out_reg;
    logic [7:0]         red_reg;
    logic [7:0]         green_reg;
    logic [7:0]         blue_reg;

    mul_ops_t                 ops;
    logic signed [PROD_W-1:0] p0;
    logic signed [PROD_W-1:0] p1;
    logic signed [PROD_W-1:0] p2;

    logic signed [SQ_W-1:0]   x2;
    logic signed [SQ_W-1:0]   y2;
    logic signed [SQ_W-1:0]   xy2;
    logic signed [SUM_W-1:0]  sum_sq;
    logic signed [SUM_W-1:0]  nx_full;
    logic signed [SUM_W-1:0]  ny_full;
    logic signed [WIDE_W-1:0] sx_full;
    logic signed [WIDE_W-1:0] sy_full;
    logic                     escaped;
    logic                     done;
    logic                     out_free;
    logic                     out_load;
    logic [7:0]               n_val;

    jei_mul_unit u_mul (
        .clk (clk),
        .ops (ops),
        .p0  (p0),
        .p1  (p1),
        .p2  (p2)
    );

    // iteration arithmetic
    always_comb
    begin
        x2      = SQ_W'(p0 >>> FRAC_BITS);
        y2      = SQ_W'(p1 >>> FRAC_BITS);
        xy2     = SQ_W'(p2 >>> (FRAC_BITS - 1));
        sum_sq  = SUM_W'(x2) + SUM_W'(y2);
        nx_full = SUM_W'(x2) - SUM_W'(y2) + SUM_W'(c_real_reg);
        ny_full = SUM_W'(xy2) + SUM_W'(c_imag_reg);
        sx_full = WIDE_W'(x_min_reg) + WIDE_W'(p0);
        sy_full = WIDE_W'(y_max_reg) - WIDE_W'(p1);
        escaped = sum_sq > ESC_LIMIT;
        done    = escaped || (count_reg > {1'b0, max_iter_reg});
        if (!escaped)
        begin
            n_val = 8'd0;
        end
        else if (count_reg[CNT_W-1])
        begin
            n_val = 8'hFF;
        end
        else
        begin
            n_val = count_reg[7:0];
        end
    end

    assign out_free = !out_valid_reg || !result_stall;
    assign out_load = (state_reg == ST_UPD) && done && out_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pixel_valid)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:   state_next = ST_ROW;
            ST_ROW:   state_next = ST_COL;
            ST_COL:   state_next = ST_MUL;
            ST_MUL:   state_next = ST_START;
            ST_START: state_next = ST_SQ;
            ST_SQ:    state_next = ST_UPD;
            ST_UPD:
            begin
                if (!done)
                begin
                    state_next = ST_SQ;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer: multiplier operands and input stall
    always_comb
    begin
        ops         = '0;
        pixel_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                pixel_stall = 1'b0;
            end
            ST_DIV:
            begin
                ops.a2 = OPND_W'(idx_reg);
                ops.b2 = OPND_W'(DIV_MUL);
            end
            ST_MUL:
            begin
                ops.a0 = OPND_W'(col_reg);
                ops.b0 = OPND_W'(x_step_reg);
                ops.a1 = OPND_W'(row_reg);
                ops.b1 = OPND_W'(y_step_reg);
            end
            // products are kept alive while a finished pixel waits for the output
            ST_SQ, ST_UPD:
            begin
                ops.a0 = OPND_W'(x_reg);
                ops.b0 = OPND_W'(x_reg);
                ops.a1 = OPND_W'(y_reg);
                ops.b1 = OPND_W'(y_reg);
                ops.a2 = OPND_W'(x_reg);
                ops.b2 = OPND_W'(y_reg);
            end
            default:
            begin
                ops = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg    <= -32'sd402653184;
            y_max_reg    <= 32'sd402653184;
            x_step_reg   <= 31'd786432;
            y_step_reg   <= 31'd786432;
            c_real_reg   <= -31'sd214748365;
            c_imag_reg   <= 31'sd41875931;
            max_iter_reg <= 8'd200;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_X_MIN:    x_min_reg    <= cfg_data;
                CFG_Y_MAX:    y_max_reg    <= cfg_data;
                CFG_X_STEP:   x_step_reg   <= cfg_data[30:0];
                CFG_Y_STEP:   y_step_reg   <= cfg_data[30:0];
                CFG_C_REAL:   c_real_reg   <= cfg_data[30:0];
                CFG_C_IMAG:   c_imag_reg   <= cfg_data[30:0];
                CFG_MAX_ITER: max_iter_reg <= cfg_data[7:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                idx_reg   <= pixel_index;
                count_reg <= CNT_W'(1);
            end
            ST_ROW:
            begin
                row_reg <= p2[DIV_SH +: ROW_W];
            end
            ST_COL:
            begin
                col_reg <= COL_W'(idx_reg - IDX_W'(IDX_W'(row_reg) * DIM_U));
            end
            ST_START:
            begin
                x_reg <= sat32(sx_full);
                y_reg <= sat32(sy_full);
            end
            ST_UPD:
            begin
                if (!done)
                begin
                    x_reg     <= sat32(WIDE_W'(nx_full));
                    y_reg     <= sat32(WIDE_W'(ny_full));
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            cnt_out_reg <= n_val;
            red_reg     <= {n_val[5:0], 2'b00};
            green_reg   <= {n_val[6:0], 1'b0};
            blue_reg    <= {n_val[5:0], 2'b00} + {n_val[6:0], 1'b0};
        end
    end

    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign escape_count = cnt_out_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;

    // input is only taken while the sequencer is idle
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> pixel_stall)
        else $error("pixel input open while busy");

    // a transfer starts the setup sequence
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && !pixel_stall) |=> (state_reg == ST_DIV))
        else $error("accepted pixel did not start setup");

    // the counter never runs past the limit plus one
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD) |-> (count_reg <= ({1'b0, max_iter_reg} + CNT_W'(1))))
        else $error("iteration counter beyond limit");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |-> !out_load)
        else $error("result register overwritten while stalled");

endmodule
